// ===== hdl/lifu_pkg.sv =====
// ----------------------------------------------------------------------------
// lifu_pkg: shared types and constants for the linear interpolation upsampler
// Request payloads, lane control bundle, sequencer states and divider sizing.
// ----------------------------------------------------------------------------
package lifu_pkg;

    localparam int CONT_LANES   = 4;
    localparam int DISC_LANES   = 2;
    localparam int WORD_W       = 32;
    localparam int FACTOR_W     = 6;
    localparam int MAX_FACTOR   = 32;
    localparam int FACTOR_RESET = 4;

    // Step counter for emitted frames, 0 .. MAX_FACTOR-1
    localparam int K_W = $clog2(MAX_FACTOR);

    // Divider: |cur - prev| fits in WORD_W bits, remainder stays below MAX_FACTOR
    localparam int DIV_W     = WORD_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = $clog2(MAX_FACTOR);

    typedef struct packed {
        logic signed [WORD_W-1:0] in_cont_0;
        logic signed [WORD_W-1:0] in_cont_1;
        logic signed [WORD_W-1:0] in_cont_2;
        logic signed [WORD_W-1:0] in_cont_3;
        logic [WORD_W-1:0]        in_disc_0;
        logic [WORD_W-1:0]        in_disc_1;
        logic                     last_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_cont_0;
        logic signed [WORD_W-1:0] out_cont_1;
        logic signed [WORD_W-1:0] out_cont_2;
        logic signed [WORD_W-1:0] out_cont_3;
        logic [WORD_W-1:0]        out_disc_0;
        logic [WORD_W-1:0]        out_disc_1;
        logic                     last_of_run;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic emit_step;
    } lane_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT,
        ST_FINAL
    } state_t;

endpackage

// ===== hdl/lifu_lane.sv =====
// ----------------------------------------------------------------------------
// lifu_lane: one continuous-lane interpolation core
// Divides |cur - prev| by the factor (DIV_BITS quotient bits per cycle), then
// walks prev + trunc(k*diff/L) one step per emitted frame using the quotient
// and remainder, so no multiply or divide is needed per output.
// ----------------------------------------------------------------------------
module lifu_lane (
    input  logic                           clk,
    input  lifu_pkg::lane_ctrl_t           ctrl,
    input  logic [lifu_pkg::FACTOR_W-1:0]  factor,
    input  logic [lifu_pkg::WORD_W-1:0]    held_val,
    input  logic [lifu_pkg::WORD_W-1:0]    cur_val,
    output logic [lifu_pkg::WORD_W-1:0]    val
);

    logic                          neg_reg,   neg_next;
    logic [lifu_pkg::DIV_W-1:0]    quo_reg,   quo_next;
    logic [lifu_pkg::REM_W-1:0]    rem_reg,   rem_next;
    logic [lifu_pkg::REM_W-1:0]    acc_r_reg, acc_r_next;
    logic [lifu_pkg::WORD_W-1:0]   val_reg,   val_next;

    logic [lifu_pkg::WORD_W:0]     diff;
    logic [lifu_pkg::WORD_W:0]     diff_neg;
    logic [lifu_pkg::WORD_W-1:0]   mag;

    logic [lifu_pkg::REM_W:0]      trial;
    logic [lifu_pkg::REM_W-1:0]    rem_w;
    logic [lifu_pkg::DIV_W-1:0]    quo_w;

    logic [lifu_pkg::REM_W:0]      sum_r;
    logic [lifu_pkg::REM_W:0]      sum_r_adj;
    logic                          carry;
    logic [lifu_pkg::WORD_W-1:0]   step_val;

    always_comb
    begin
        diff     = {cur_val[lifu_pkg::WORD_W-1], cur_val}
                 - {held_val[lifu_pkg::WORD_W-1], held_val};
        diff_neg = ~diff + 1'b1;
        mag      = diff[lifu_pkg::WORD_W] ? diff_neg[lifu_pkg::WORD_W-1:0]
                                          : diff[lifu_pkg::WORD_W-1:0];

        // restoring division, MSB first, quotient bits shift in at the bottom
        rem_w = rem_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int i = 0; i < lifu_pkg::DIV_BITS; i++)
        begin
            trial = {rem_w, quo_w[lifu_pkg::DIV_W-1]};
            quo_w = {quo_w[lifu_pkg::DIV_W-2:0], 1'b0};
            if (trial >= factor)
            begin
                trial    = trial - factor;
                quo_w[0] = 1'b1;
            end
            rem_w = trial[lifu_pkg::REM_W-1:0];
        end

        // k*|d| = q*L + r; each step adds Q and R, with one carry when r wraps
        sum_r     = {1'b0, acc_r_reg} + {1'b0, rem_reg};
        carry     = (sum_r >= factor);
        sum_r_adj = carry ? (sum_r - factor) : sum_r;
        // neg: val - Q - c  ==  val + ~Q + (1 - c)
        step_val  = val_reg + (quo_reg ^ {lifu_pkg::WORD_W{neg_reg}})
                  + {{(lifu_pkg::WORD_W-1){1'b0}}, neg_reg ^ carry};

        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        acc_r_next = acc_r_reg;
        val_next   = val_reg;
        if (ctrl.start)
        begin
            neg_next   = diff[lifu_pkg::WORD_W];
            quo_next   = mag;
            rem_next   = '0;
            acc_r_next = '0;
            val_next   = held_val;
        end
        else if (ctrl.div_step)
        begin
            quo_next = quo_w;
            rem_next = rem_w;
        end
        else if (ctrl.emit_step)
        begin
            acc_r_next = sum_r_adj[lifu_pkg::REM_W-1:0];
            val_next   = step_val;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        acc_r_reg <= acc_r_next;
        val_reg   <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== hdl/lifu_out.sv =====
// ----------------------------------------------------------------------------
// lifu_out: merge stage and output register
// Gathers the lane values (or the current frame for the final copy) with the
// discrete words and last flag into one request and holds it until taken.
// ----------------------------------------------------------------------------
module lifu_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          sel_final,
    input  logic                          last_flag,
    input  logic [lifu_pkg::WORD_W-1:0]   lane_val  [lifu_pkg::CONT_LANES],
    input  logic [lifu_pkg::WORD_W-1:0]   held_disc [lifu_pkg::DISC_LANES],
    input  logic [lifu_pkg::WORD_W-1:0]   cur_cont  [lifu_pkg::CONT_LANES],
    input  logic [lifu_pkg::WORD_W-1:0]   cur_disc  [lifu_pkg::DISC_LANES],
    output logic                          slot_free,
    input  logic                          out_stall,
    output logic                          out_valid,
    output lifu_pkg::out_item_t           out_data
);

    logic                   out_valid_reg, out_valid_next;
    lifu_pkg::out_item_t    out_data_reg,  out_data_next;
    lifu_pkg::out_item_t    item;

    logic [lifu_pkg::WORD_W-1:0] cont_sel [lifu_pkg::CONT_LANES];
    logic [lifu_pkg::WORD_W-1:0] disc_sel [lifu_pkg::DISC_LANES];

    always_comb
    begin
        for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
        begin
            cont_sel[j] = sel_final ? cur_cont[j] : lane_val[j];
        end
        for (int j = 0; j < lifu_pkg::DISC_LANES; j++)
        begin
            disc_sel[j] = sel_final ? cur_disc[j] : held_disc[j];
        end

        item.out_cont_0  = cont_sel[0];
        item.out_cont_1  = cont_sel[1];
        item.out_cont_2  = cont_sel[2];
        item.out_cont_3  = cont_sel[3];
        item.out_disc_0  = disc_sel[0];
        item.out_disc_1  = disc_sel[1];
        item.last_of_run = last_flag;

        slot_free      = !out_valid_reg || !out_stall;
        out_valid_next = push || (out_valid_reg && out_stall);
        out_data_next  = push ? item : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/linear_interp_frame_upsampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_frame_upsampler: linear interpolation frame upsampler, top level
// A request with a held frame is accepted in ST_IDLE, then the lanes divide in
// ST_DIVIDE at 4 quotient bits per step and emit the L frames from ST_EMIT.
// Requests are taken only in ST_IDLE, so each request is finished before the next
// one is accepted; output stalls hold the emitted frames and the final copy.
// Reset: factor 4, no frame held, output register empty; sequencer idle.
// ----------------------------------------------------------------------------
module linear_interp_frame_upsampler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lifu_pkg::FACTOR_W-1:0]  cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lifu_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lifu_pkg::out_item_t            out_data
);

    lifu_pkg::state_t                  state_reg, state_next;
    logic [lifu_pkg::FACTOR_W-1:0]     factor_reg, factor_next;
    logic [lifu_pkg::FACTOR_W-1:0]     l_reg, l_next;
    logic [lifu_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [lifu_pkg::K_W-1:0]          k_reg, k_next;
    logic                              have_held_reg, have_held_next;
    logic                              cur_last_reg;

    logic [lifu_pkg::WORD_W-1:0] held_cont_reg [lifu_pkg::CONT_LANES];
    logic [lifu_pkg::WORD_W-1:0] held_disc_reg [lifu_pkg::DISC_LANES];
    logic [lifu_pkg::WORD_W-1:0] cur_cont_reg  [lifu_pkg::CONT_LANES];
    logic [lifu_pkg::WORD_W-1:0] cur_disc_reg  [lifu_pkg::DISC_LANES];

    logic [lifu_pkg::WORD_W-1:0] in_cont  [lifu_pkg::CONT_LANES];
    logic [lifu_pkg::WORD_W-1:0] in_disc  [lifu_pkg::DISC_LANES];
    logic [lifu_pkg::WORD_W-1:0] lane_val [lifu_pkg::CONT_LANES];

    lifu_pkg::lane_ctrl_t          lane_ctrl;
    logic [lifu_pkg::FACTOR_W-1:0] eff_factor;
    logic                          accept;
    logic                          k_last;
    logic                          push;
    logic                          sel_final;
    logic                          last_flag;
    logic                          slot_free;
    logic                          load_in_held;
    logic                          cur_to_held;
    logic                          clear_held;

    always_comb
    begin
        in_cont[0] = in_data.in_cont_0;
        in_cont[1] = in_data.in_cont_1;
        in_cont[2] = in_data.in_cont_2;
        in_cont[3] = in_data.in_cont_3;
        in_disc[0] = in_data.in_disc_0;
        in_disc[1] = in_data.in_disc_1;

        // zero acts as 1, anything above the maximum saturates
        if (factor_reg == '0)
        begin
            eff_factor = lifu_pkg::FACTOR_W'(1);
        end
        else if (factor_reg > lifu_pkg::FACTOR_W'(lifu_pkg::MAX_FACTOR))
        begin
            eff_factor = lifu_pkg::FACTOR_W'(lifu_pkg::MAX_FACTOR);
        end
        else
        begin
            eff_factor = factor_reg;
        end

        factor_next = cfg_wr_en ? cfg_wr_data : factor_reg;
        k_last      = (({1'b0, k_reg}) + 1'b1) == l_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        in_stall       = 1'b1;
        accept         = 1'b0;
        lane_ctrl      = '0;
        push           = 1'b0;
        sel_final      = 1'b0;
        last_flag      = 1'b0;
        load_in_held   = 1'b0;
        cur_to_held    = 1'b0;
        clear_held     = 1'b0;

        case (state_reg)
            lifu_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    accept = 1'b1;
                    l_next = eff_factor;
                    if (have_held_reg)
                    begin
                        lane_ctrl.start = 1'b1;
                        div_cnt_next    = '0;
                        state_next      = lifu_pkg::ST_DIVIDE;
                    end
                    else if (in_data.last_frame)
                    begin
                        state_next = lifu_pkg::ST_FINAL;
                    end
                    else
                    begin
                        // first frame of a sequence: just hold it
                        load_in_held = 1'b1;
                    end
                end
            end

            lifu_pkg::ST_DIVIDE:
            begin
                lane_ctrl.div_step = 1'b1;
                div_cnt_next       = div_cnt_reg + 1'b1;
                if (div_cnt_reg == lifu_pkg::DIV_CNT_W'(lifu_pkg::DIV_STEPS - 1))
                begin
                    k_next     = '0;
                    state_next = lifu_pkg::ST_EMIT;
                end
            end

            lifu_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    push                = 1'b1;
                    lane_ctrl.emit_step = 1'b1;
                    last_flag           = !cur_last_reg && k_last;
                    k_next              = k_reg + 1'b1;
                    if (k_last)
                    begin
                        if (cur_last_reg)
                        begin
                            state_next = lifu_pkg::ST_FINAL;
                        end
                        else
                        begin
                            cur_to_held = 1'b1;
                            state_next  = lifu_pkg::ST_IDLE;
                        end
                    end
                end
            end

            lifu_pkg::ST_FINAL:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    sel_final  = 1'b1;
                    last_flag  = 1'b1;
                    clear_held = 1'b1;
                    state_next = lifu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lifu_pkg::ST_IDLE;
            end
        endcase

        have_held_next = have_held_reg;
        if (load_in_held || cur_to_held)
        begin
            have_held_next = 1'b1;
        end
        else if (clear_held)
        begin
            have_held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lifu_pkg::ST_IDLE;
            factor_reg    <= lifu_pkg::FACTOR_W'(lifu_pkg::FACTOR_RESET);
            div_cnt_reg   <= '0;
            k_reg         <= '0;
            have_held_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            div_cnt_reg   <= div_cnt_next;
            k_reg         <= k_next;
            have_held_reg <= have_held_next;
        end
    end

    // frame storage
    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        if (accept)
        begin
            cur_last_reg <= in_data.last_frame;
            cur_cont_reg <= in_cont;
            cur_disc_reg <= in_disc;
        end
        if (load_in_held)
        begin
            held_cont_reg <= in_cont;
            held_disc_reg <= in_disc;
        end
        else if (cur_to_held)
        begin
            held_cont_reg <= cur_cont_reg;
            held_disc_reg <= cur_disc_reg;
        end
        else if (clear_held)
        begin
            for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
            begin
                held_cont_reg[j] <= '0;
            end
            for (int j = 0; j < lifu_pkg::DISC_LANES; j++)
            begin
                held_disc_reg[j] <= '0;
            end
        end
    end

    for (genvar j = 0; j < lifu_pkg::CONT_LANES; j++)
    begin : g_lane
        lifu_lane u_lane (
            .clk      (clk),
            .ctrl     (lane_ctrl),
            .factor   (l_reg),
            .held_val (held_cont_reg[j]),
            .cur_val  (in_cont[j]),
            .val      (lane_val[j])
        );
    end

    lifu_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sel_final (sel_final),
        .last_flag (last_flag),
        .lane_val  (lane_val),
        .held_disc (held_disc_reg),
        .cur_cont  (cur_cont_reg),
        .cur_disc  (cur_disc_reg),
        .slot_free (slot_free),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_held_goes_to_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && have_held_reg) |=> (state_reg == lifu_pkg::ST_DIVIDE))
        else $error("request with a held frame did not start the divider");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lifu_pkg::ST_EMIT) |-> ({1'b0, k_reg} < l_reg))
        else $error("emit step count ran past the factor");

    a_factor_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lifu_pkg::ST_DIVIDE) |->
            (l_reg != '0 && l_reg <= lifu_pkg::FACTOR_W'(lifu_pkg::MAX_FACTOR)))
        else $error("latched factor out of range");

    a_final_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lifu_pkg::ST_FINAL && push) |=> !have_held_reg)
        else $error("held frame survived the final copy");

endmodule

// ===== test/linear_interp_frame_upsampler_tb.sv =====
// ----------------------------------------------------------------------------
// linear_interp_frame_upsampler_tb: self-checking bench for the frame upsampler
// Frames go in through a request channel, a local predictor builds the
// interpolated frames each request should produce, and every output request
// is compared field by field in arrival order. Both sides idle in random
// bursts, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module linear_interp_frame_upsampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF     = 4;
    localparam int  RESET_CYCLES = 12;
    localparam int  SETTLE       = 48;
    localparam int  CYCLE_LIMIT  = 600000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [lifu_pkg::FACTOR_W-1:0] cfg_wr_data;
    logic                          in_valid;
    logic                          in_stall;
    lifu_pkg::in_item_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    lifu_pkg::out_item_t           out_data;

    linear_interp_frame_upsampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // predictor state
    logic signed [lifu_pkg::WORD_W-1:0] held_cont [lifu_pkg::CONT_LANES];
    logic [lifu_pkg::WORD_W-1:0]        held_disc [lifu_pkg::DISC_LANES];
    logic                               have_prev;
    logic [lifu_pkg::FACTOR_W-1:0]      factor_reg;

    lifu_pkg::out_item_t frames_due [$];
    lifu_pkg::out_item_t want;
    int                  mismatches;
    int                  cycle_count;
    bit                  idle_on;
    int                  stall_hold;
    int                  stall_left;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side: long hold-off first, then random stall bursts
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall = 1'b1;
            stall_hold--;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 5);
        end
        else
            out_stall = 1'b0;
    end

    task automatic check_word(input string field,
                              input logic [lifu_pkg::WORD_W-1:0] exp_w,
                              input logic [lifu_pkg::WORD_W-1:0] act_w);
        if (exp_w !== act_w)
        begin
            $display("%0t mismatch %s: expected %h, got %h", $time, field, exp_w, act_w);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t unexpected output request: expected none, got %h",
                         $time, out_data);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_word("out_cont_0", want.out_cont_0, out_data.out_cont_0);
                check_word("out_cont_1", want.out_cont_1, out_data.out_cont_1);
                check_word("out_cont_2", want.out_cont_2, out_data.out_cont_2);
                check_word("out_cont_3", want.out_cont_3, out_data.out_cont_3);
                check_word("out_disc_0", want.out_disc_0, out_data.out_disc_0);
                check_word("out_disc_1", want.out_disc_1, out_data.out_disc_1);
                check_word("last_of_run", lifu_pkg::WORD_W'(want.last_of_run),
                           lifu_pkg::WORD_W'(out_data.last_of_run));
            end
        end
    end

    function automatic int unsigned active_factor();
        if (factor_reg == 0)
            return 1;
        if (factor_reg > lifu_pkg::MAX_FACTOR)
            return lifu_pkg::MAX_FACTOR;
        return factor_reg;
    endfunction

    // queue the frames one accepted request produces and advance the held frame
    function automatic void predict_frames(input lifu_pkg::in_item_t frame);
        logic signed [lifu_pkg::WORD_W-1:0] cur [lifu_pkg::CONT_LANES];
        logic [lifu_pkg::WORD_W-1:0]        lane_val [lifu_pkg::CONT_LANES];
        longint                             diff;
        int unsigned                        steps;
        lifu_pkg::out_item_t                o;
        cur[0] = frame.in_cont_0;
        cur[1] = frame.in_cont_1;
        cur[2] = frame.in_cont_2;
        cur[3] = frame.in_cont_3;
        if (have_prev)
        begin
            steps = active_factor();
            for (int k = 0; k < steps; k++)
            begin
                for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
                begin
                    diff = longint'(cur[j]) - longint'(held_cont[j]);
                    lane_val[j] = lifu_pkg::WORD_W'(longint'(held_cont[j])
                                  + (longint'(k) * diff) / longint'(steps));
                end
                o.out_cont_0  = lane_val[0];
                o.out_cont_1  = lane_val[1];
                o.out_cont_2  = lane_val[2];
                o.out_cont_3  = lane_val[3];
                o.out_disc_0  = held_disc[0];
                o.out_disc_1  = held_disc[1];
                o.last_of_run = !frame.last_frame && (k + 1 == steps);
                frames_due.push_back(o);
            end
        end
        if (frame.last_frame)
        begin
            o.out_cont_0  = frame.in_cont_0;
            o.out_cont_1  = frame.in_cont_1;
            o.out_cont_2  = frame.in_cont_2;
            o.out_cont_3  = frame.in_cont_3;
            o.out_disc_0  = frame.in_disc_0;
            o.out_disc_1  = frame.in_disc_1;
            o.last_of_run = 1'b1;
            frames_due.push_back(o);
            for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
                held_cont[j] = '0;
            for (int j = 0; j < lifu_pkg::DISC_LANES; j++)
                held_disc[j] = '0;
            have_prev = 1'b0;
        end
        else
        begin
            for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
                held_cont[j] = cur[j];
            held_disc[0] = frame.in_disc_0;
            held_disc[1] = frame.in_disc_1;
            have_prev = 1'b1;
        end
    endfunction

    function automatic logic [lifu_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            3: return lifu_pkg::WORD_W'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic lifu_pkg::in_item_t rand_frame(input logic last);
        lifu_pkg::in_item_t f;
        f.in_cont_0  = rand_word();
        f.in_cont_1  = rand_word();
        f.in_cont_2  = rand_word();
        f.in_cont_3  = rand_word();
        f.in_disc_0  = $urandom;
        f.in_disc_1  = $urandom;
        f.last_frame = last;
        return f;
    endfunction

    function automatic lifu_pkg::in_item_t flat_frame(
        input logic [lifu_pkg::WORD_W-1:0] cont_w,
        input logic [lifu_pkg::WORD_W-1:0] disc_w,
        input logic last);
        lifu_pkg::in_item_t f;
        f.in_cont_0  = cont_w;
        f.in_cont_1  = cont_w;
        f.in_cont_2  = cont_w;
        f.in_cont_3  = cont_w;
        f.in_disc_0  = disc_w;
        f.in_disc_1  = ~disc_w;
        f.last_frame = last;
        return f;
    endfunction

    // called at a falling edge, returns at a falling edge with valid low
    task automatic send_frame(input lifu_pkg::in_item_t frame);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_data  = frame;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frames(frame);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_factor(input logic [lifu_pkg::FACTOR_W-1:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        factor_reg = value;
    endtask

    task automatic test_default_factor();
        send_frame(rand_frame(1'b0));
        send_frame(rand_frame(1'b0));
        send_frame(rand_frame(1'b1));
    endtask

    task automatic test_one_frame_run();
        send_frame(rand_frame(1'b1));
        send_frame(flat_frame(32'h0, 32'h0, 1'b1));
    endtask

    task automatic test_lane_extremes();
        set_factor(lifu_pkg::FACTOR_W'(lifu_pkg::MAX_FACTOR));
        send_frame(flat_frame(32'h8000_0000, 32'h0, 1'b0));
        send_frame(flat_frame(32'h7fff_ffff, 32'hffff_ffff, 1'b0));
        send_frame(flat_frame(32'h8000_0000, 32'h5a5a_a5a5, 1'b1));
        set_factor(lifu_pkg::FACTOR_W'(1));
        send_frame(flat_frame(32'h7fff_ffff, 32'hffff_ffff, 1'b0));
        send_frame(flat_frame(32'hffff_ffff, 32'h0, 1'b1));
    endtask

    // zero acts as one, anything above the maximum saturates
    task automatic test_factor_clamping();
        logic [lifu_pkg::FACTOR_W-1:0] odd_factors [3];
        odd_factors = '{6'd0, 6'd33, 6'd63};
        foreach (odd_factors[i])
        begin
            set_factor(odd_factors[i]);
            send_frame(rand_frame(1'b0));
            send_frame(rand_frame(1'b1));
        end
    endtask

    task automatic test_backpressure();
        set_factor(lifu_pkg::FACTOR_W'(8));
        @(posedge clk);
        stall_hold = 300;
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            send_frame(rand_frame(i == 11));
    endtask

    task automatic test_random_runs();
        int run_len;
        for (int p = 0; p < 6; p++)
        begin
            set_factor(lifu_pkg::FACTOR_W'(p == 3 ? $urandom_range(9, 63)
                                                  : $urandom_range(0, 8)));
            idle_on = (p != 5);
            for (int sent = 0; sent < 58; )
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray frame with a random flag
                    send_frame(rand_frame(1'($urandom_range(0, 1))));
                    sent++;
                end
                else
                begin
                    run_len = $urandom_range(1, 8);
                    for (int i = 0; i < run_len; i++)
                        send_frame(rand_frame(i == run_len - 1));
                    sent += run_len;
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        idle_on     = 1'b0;
        stall_hold  = 0;
        stall_left  = 0;
        mismatches  = 0;
        cycle_count = 0;
        have_prev   = 1'b0;
        factor_reg  = lifu_pkg::FACTOR_W'(lifu_pkg::FACTOR_RESET);
        for (int j = 0; j < lifu_pkg::CONT_LANES; j++)
            held_cont[j] = '0;
        for (int j = 0; j < lifu_pkg::DISC_LANES; j++)
            held_disc[j] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n   = 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        test_default_factor();
        test_one_frame_run();
        test_lane_extremes();
        test_factor_clamping();
        test_backpressure();
        test_random_runs();

        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
